// File: rtl/bsmd_pkg.sv
// Shared types, constants and the bank table of the bank-switched memory decoder.
`default_nettype none

package bsmd_pkg;

    localparam int COLOR_DEPTH = 1024;
    localparam logic [15:0] COLOR_BASE = 16'hD800;
    localparam logic [15:0] VIDEO_MASK = 16'h003F;
    localparam logic [15:0] CIA_MASK   = 16'h000F;
    localparam logic [2:0]  PORT_DATA_RESET = 3'h7;

    typedef enum logic [3:0] {
        RG_RAM    = 4'd0,
        RG_PORT   = 4'd1,
        RG_BASIC  = 4'd2,
        RG_CHAR   = 4'd3,
        RG_KERNAL = 4'd4,
        RG_CARTLO = 4'd5,
        RG_CARTHI = 4'd6,
        RG_VIDEO  = 4'd7,
        RG_SOUND  = 4'd8,
        RG_COLOR  = 4'd9,
        RG_CIA1   = 4'd10,
        RG_CIA2   = 4'd11,
        RG_IO1    = 4'd12,
        RG_IO2    = 4'd13,
        RG_NONE   = 4'd14,
        RG_IOBLK  = 4'd15
    } region_t;

    // Where the read data of an item comes from.
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_RAM,
        SRC_COLOR,
        SRC_DIR,
        SRC_PORT,
        SRC_OPEN
    } src_t;

    typedef struct packed {
        region_t     region;
        logic [15:0] local_addr;
        src_t        src;
        logic        main_we;
        logic        color_we;
        logic        dir_we;
        logic        port_we;
    } dec_t;

    // Columns: $1000-$7FFF, $8000-$9FFF, $A000-$BFFF, $C000-$CFFF, $D000-$DFFF, $E000-$FFFF
    localparam region_t BANK_ROWS [32][6] = '{
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_CARTHI, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_CARTLO, RG_CARTHI, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_IOBLK, RG_RAM},
        '{RG_RAM, RG_RAM, RG_CARTHI, RG_RAM, RG_IOBLK, RG_KERNAL},
        '{RG_RAM, RG_CARTLO, RG_CARTHI, RG_RAM, RG_IOBLK, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_CHAR, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_CARTLO, RG_BASIC, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_IOBLK, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_IOBLK, RG_KERNAL},
        '{RG_RAM, RG_CARTLO, RG_BASIC, RG_RAM, RG_IOBLK, RG_KERNAL},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_NONE, RG_CARTLO, RG_NONE, RG_NONE, RG_IOBLK, RG_CARTHI},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_CHAR, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_BASIC, RG_RAM, RG_CHAR, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_IOBLK, RG_RAM},
        '{RG_RAM, RG_RAM, RG_RAM, RG_RAM, RG_IOBLK, RG_KERNAL},
        '{RG_RAM, RG_RAM, RG_BASIC, RG_RAM, RG_IOBLK, RG_KERNAL}
    };

    // Map the top address nibble to a bank table column.
    function automatic logic [2:0] nibble_col(input logic [3:0] nib);
        logic [2:0] col;
        case (nib)
            4'h8, 4'h9: col = 3'd1;
            4'hA, 4'hB: col = 3'd2;
            4'hC:       col = 3'd3;
            4'hD:       col = 3'd4;
            4'hE, 4'hF: col = 3'd5;
            default:    col = 3'd0;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bank_switched_memory_decoder.sv
// Top level of the bank-switched memory decoder.
// Each bus access is one item. It is registered on acceptance, decoded from the
// input register against the current processor port, performs the RAM, color
// RAM or port write when it advances, and is then registered in the result register.
// One item per cycle is sustained while the output is not stalled; the rate is set by the single
// port of the main RAM, which serves one read or one write per item. Port
// writes take effect for the very next item. RAM contents are undefined after
// reset until written; the port resets to data 0x07 and direction 0.
`default_nettype none

module bank_switched_memory_decoder #(
    parameter int COLOR_DEPTH = bsmd_pkg::COLOR_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  write_data,
    input  wire logic        game_line,
    input  wire logic        exrom_line,
    input  wire logic [7:0]  open_bus,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       region,
    output logic [15:0]      local_addr,
    output logic [7:0]       read_data,
    output logic             data_valid,
    output logic             ultimax
);

    logic        s1_valid_reg, s1_valid_next;
    logic        op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wd_reg;
    logic        game_reg;
    logic        exrom_reg;
    logic [7:0]  ob_reg;

    logic [7:0]  port_dir_reg, port_dir_next;
    logic [7:0]  port_data_reg, port_data_next;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        region_reg;
    logic [15:0]       local_reg;
    bsmd_pkg::src_t    src_reg;
    logic [7:0]        direct_reg, direct_next;
    logic [3:0]        ob_hi_reg;
    logic              ultimax_reg;

    logic           advance;
    logic           in_take;
    logic           fire;
    bsmd_pkg::dec_t dec;
    logic [7:0]     main_q;
    logic [3:0]     color_q;

    assign advance  = ~out_valid_reg | ~out_stall;
    assign in_stall = s1_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;
    assign fire     = s1_valid_reg & advance;

    bsmd_decode u_decode (
        .op         (op_reg),
        .addr       (addr_reg),
        .game_line  (game_reg),
        .exrom_line (exrom_reg),
        .port_bank  (port_data_reg[2:0]),
        .dec        (dec)
    );

    bsmd_mem #(
        .COLOR_DEPTH (COLOR_DEPTH)
    ) u_mem (
        .clk      (clk),
        .en       (fire),
        .main_we  (dec.main_we),
        .color_we (dec.color_we),
        .addr     (addr_reg),
        .wdata    (wd_reg),
        .main_q   (main_q),
        .color_q  (color_q)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
        port_dir_next  = (fire && dec.dir_we) ? wd_reg : port_dir_reg;
        port_data_next = (fire && dec.port_we) ? wd_reg : port_data_reg;
    end

    always_comb
    begin
        case (dec.src)
            bsmd_pkg::SRC_DIR:  direct_next = port_dir_reg;
            bsmd_pkg::SRC_PORT: direct_next = port_data_reg;
            bsmd_pkg::SRC_OPEN: direct_next = ob_reg;
            default:            direct_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_dir_reg  <= 8'h00;
            port_data_reg <= {5'd0, bsmd_pkg::PORT_DATA_RESET};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            port_dir_reg  <= port_dir_next;
            port_data_reg <= port_data_next;
        end
    end

    // Input register: load on acceptance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= op;
            addr_reg  <= addr;
            wd_reg    <= write_data;
            game_reg  <= game_line;
            exrom_reg <= exrom_line;
            ob_reg    <= open_bus;
        end
    end

    // Result register: advance with the memory read data.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            region_reg  <= dec.region;
            local_reg   <= dec.local_addr;
            src_reg     <= dec.src;
            direct_reg  <= direct_next;
            ob_hi_reg   <= ob_reg[7:4];
            ultimax_reg <= exrom_reg & ~game_reg;
        end
    end

    always_comb
    begin
        case (src_reg)
            bsmd_pkg::SRC_RAM:   read_data = main_q;
            bsmd_pkg::SRC_COLOR: read_data = {ob_hi_reg, color_q};
            default:             read_data = direct_reg;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign region     = region_reg;
    assign local_addr = local_reg;
    assign data_valid = (src_reg != bsmd_pkg::SRC_ZERO);
    assign ultimax    = ultimax_reg;

endmodule

`default_nettype wire

// File: rtl/bsmd_decode.sv
// Address decoder: bank table lookup, I/O block split and per-item actions.
`default_nettype none

module bsmd_decode (
    input  wire logic           op,
    input  wire logic [15:0]    addr,
    input  wire logic           game_line,
    input  wire logic           exrom_line,
    input  wire logic [2:0]     port_bank,
    output bsmd_pkg::dec_t      dec
);

    logic [4:0]        bank;
    bsmd_pkg::region_t raw;
    bsmd_pkg::region_t mapped;
    logic [15:0]       local_addr;

    assign bank = {exrom_line, game_line, port_bank};

    always_comb
    begin
        if (addr[15:12] == 4'h0)
        begin
            raw = (addr[15:1] == 15'd0) ? bsmd_pkg::RG_PORT : bsmd_pkg::RG_RAM;
        end
        else
        begin
            raw = bsmd_pkg::BANK_ROWS[bank][bsmd_pkg::nibble_col(addr[15:12])];
        end
    end

    // Split the I/O block by the second address nibble.
    always_comb
    begin
        mapped     = raw;
        local_addr = addr;
        if (raw == bsmd_pkg::RG_IOBLK)
        begin
            unique case (addr[11:8])
                4'h0, 4'h1, 4'h2, 4'h3:
                begin
                    mapped     = bsmd_pkg::RG_VIDEO;
                    local_addr = addr & bsmd_pkg::VIDEO_MASK;
                end
                4'h4, 4'h5, 4'h6, 4'h7: mapped = bsmd_pkg::RG_SOUND;
                4'h8, 4'h9, 4'hA, 4'hB: mapped = bsmd_pkg::RG_COLOR;
                4'hC:
                begin
                    mapped     = bsmd_pkg::RG_CIA1;
                    local_addr = addr & bsmd_pkg::CIA_MASK;
                end
                4'hD:
                begin
                    mapped     = bsmd_pkg::RG_CIA2;
                    local_addr = addr & bsmd_pkg::CIA_MASK;
                end
                4'hE:    mapped = bsmd_pkg::RG_IO1;
                default: mapped = bsmd_pkg::RG_IO2;
            endcase
        end
    end

    always_comb
    begin
        dec            = '0;
        dec.region     = mapped;
        dec.local_addr = local_addr;
        dec.src        = bsmd_pkg::SRC_ZERO;
        if (op)
        begin
            unique case (mapped) inside
                bsmd_pkg::RG_PORT:
                begin
                    dec.dir_we  = ~addr[0];
                    dec.port_we = addr[0];
                end
                bsmd_pkg::RG_RAM, bsmd_pkg::RG_BASIC, bsmd_pkg::RG_CHAR,
                bsmd_pkg::RG_KERNAL:
                begin
                    // ROM regions write through to the RAM underneath
                    dec.main_we = 1'b1;
                    dec.region  = bsmd_pkg::RG_RAM;
                end
                bsmd_pkg::RG_COLOR: dec.color_we = 1'b1;
                default: ;
            endcase
        end
        else
        begin
            unique case (mapped)
                bsmd_pkg::RG_PORT:
                    dec.src = addr[0] ? bsmd_pkg::SRC_PORT : bsmd_pkg::SRC_DIR;
                bsmd_pkg::RG_RAM:   dec.src = bsmd_pkg::SRC_RAM;
                bsmd_pkg::RG_COLOR: dec.src = bsmd_pkg::SRC_COLOR;
                bsmd_pkg::RG_NONE:  dec.src = bsmd_pkg::SRC_OPEN;
                default:            dec.src = bsmd_pkg::SRC_ZERO;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsmd_mem.sv
// Main RAM and color RAM with registered read data.
`default_nettype none

module bsmd_mem #(
    parameter int COLOR_DEPTH = bsmd_pkg::COLOR_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic        main_we,
    input  wire logic        color_we,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  wdata,
    output logic [7:0]       main_q,
    output logic [3:0]       color_q
);

    localparam int CW = $clog2(COLOR_DEPTH);

    logic [7:0]    main_ram [65536];
    logic [3:0]    color_ram [COLOR_DEPTH];
    logic [15:0]   color_off;
    logic [CW-1:0] color_idx;

    assign color_off = addr - bsmd_pkg::COLOR_BASE;
    assign color_idx = color_off[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (en && main_we)
        begin
            main_ram[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            main_q <= main_ram[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && color_we)
        begin
            color_ram[color_idx] <= wdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_q <= color_ram[color_idx];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsmd_checker.sv
// Port-level checks for the bank-switched memory decoder, bound to the top level.
`default_nettype none

module bsmd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [3:0]  region,
    input wire logic [15:0] local_addr,
    input wire logic [7:0]  read_data,
    input wire logic        data_valid
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(region) && $stable(local_addr)
            && $stable(read_data) && $stable(data_valid))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> read_data == 8'h00)
    else $error("read data not zero on an item without data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == bsmd_pkg::RG_CIA1 || region == bsmd_pkg::RG_CIA2)
            |-> local_addr[15:4] == 12'h000)
    else $error("CIA local address not masked");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == bsmd_pkg::RG_VIDEO || region == bsmd_pkg::RG_SOUND
            || region == bsmd_pkg::RG_CARTLO || region == bsmd_pkg::RG_CARTHI
            || region == bsmd_pkg::RG_BASIC || region == bsmd_pkg::RG_IO1)
            |-> !data_valid)
    else $error("external region reported data");

endmodule

bind bank_switched_memory_decoder bsmd_checker u_bsmd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .region     (region),
    .local_addr (local_addr),
    .read_data  (read_data),
    .data_valid (data_valid)
);

`default_nettype wire

// File: bench/bank_switched_memory_decoder_tb.sv
// Self-checking bench for the bank-switched memory decoder: directed and random bus accesses.
`timescale 1ns / 1ps

module bank_switched_memory_decoder_tb;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_AT     = 400;
    localparam int BUSY_FROM    = 600;
    localparam int BUSY_TO      = 700;

    // One row per bank index, six columns packed as nibbles, leftmost column first.
    localparam logic [23:0] BANK_TABLE [32] = '{
        24'h000000, 24'h000000, 24'h006034, 24'h056034,
        24'h000000, 24'h0000F0, 24'h0060F4, 24'h0560F4,
        24'h000000, 24'h000030, 24'h000034, 24'h052034,
        24'h000000, 24'h0000F0, 24'h0000F4, 24'h0520F4,
        24'hE5EEF6, 24'hE5EEF6, 24'hE5EEF6, 24'hE5EEF6,
        24'hE5EEF6, 24'hE5EEF6, 24'hE5EEF6, 24'hE5EEF6,
        24'h000000, 24'h000030, 24'h000034, 24'h002034,
        24'h000000, 24'h0000F0, 24'h0000F4, 24'h0020F4
    };

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        game;
        logic        exrom;
        logic [7:0]  obus;
        logic        drain_first;
    } access_t;

    typedef struct packed {
        bsmd_pkg::region_t region;
        logic [15:0]       local_addr;
        logic [7:0]        rdata;
        logic              dvalid;
        logic              ultimax;
    } decode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        op         = 1'b0;
    logic [15:0] addr       = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic        game_line  = 1'b1;
    logic        exrom_line = 1'b1;
    logic [7:0]  open_bus   = 8'h00;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  region;
    logic [15:0] local_addr;
    logic [7:0]  read_data;
    logic        data_valid;
    logic        ultimax;

    // Shadow of the block's storage, advanced as items are accepted.
    logic [7:0]  ram_copy [65536];
    logic [3:0]  color_copy [1024];
    logic [7:0]  port_dir_copy = 8'h00;
    logic [7:0]  port_val_copy = 8'h07;

    // Generation-time view: which cells hold data and what the bank bits will be.
    bit          ram_written [65536];
    bit          color_written [1024];
    logic [2:0]  gen_port = 3'h7;
    logic [15:0] written_addrs [$];

    access_t     access_queue [$];
    decode_t     pending_decodes [$];

    int          total_items = -1;
    int          driven_count = 0;
    int          accepted_count = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    bank_switched_memory_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .addr       (addr),
        .write_data (write_data),
        .game_line  (game_line),
        .exrom_line (exrom_line),
        .open_bus   (open_bus),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .region     (region),
        .local_addr (local_addr),
        .read_data  (read_data),
        .data_valid (data_valid),
        .ultimax    (ultimax)
    );

    always #10 clk = ~clk;

    function automatic bsmd_pkg::region_t lookup_region(input logic [2:0] port_bits,
                                                        input logic g, input logic x,
                                                        input logic [15:0] a);
        logic [4:0]        idx;
        logic [23:0]       row;
        int                col;
        bsmd_pkg::region_t r;
        if (a[15:12] == 4'h0)
            return (a < 16'd2) ? bsmd_pkg::RG_PORT : bsmd_pkg::RG_RAM;
        case (a[15:12])
            4'h8, 4'h9: col = 1;
            4'hA, 4'hB: col = 2;
            4'hC:       col = 3;
            4'hD:       col = 4;
            4'hE, 4'hF: col = 5;
            default:    col = 0;
        endcase
        idx = {x, g, port_bits};
        row = BANK_TABLE[idx];
        r = bsmd_pkg::region_t'(row[23 - 4 * col -: 4]);
        if (r == bsmd_pkg::RG_IOBLK)
        begin
            case (a[11:8])
                4'h0, 4'h1, 4'h2, 4'h3: r = bsmd_pkg::RG_VIDEO;
                4'h4, 4'h5, 4'h6, 4'h7: r = bsmd_pkg::RG_SOUND;
                4'h8, 4'h9, 4'hA, 4'hB: r = bsmd_pkg::RG_COLOR;
                4'hC:                   r = bsmd_pkg::RG_CIA1;
                4'hD:                   r = bsmd_pkg::RG_CIA2;
                4'hE:                   r = bsmd_pkg::RG_IO1;
                default:                r = bsmd_pkg::RG_IO2;
            endcase
        end
        return r;
    endfunction

    // Decode one accepted access and apply its write to the shadow storage.
    function automatic decode_t decode_access(input access_t it);
        decode_t     d;
        logic [15:0] off;
        logic [9:0]  cidx;
        off = it.addr - 16'hD800;
        cidx = off[9:0];
        d.region = lookup_region(port_val_copy[2:0], it.game, it.exrom, it.addr);
        d.local_addr = it.addr;
        d.rdata = 8'h00;
        d.dvalid = 1'b0;
        d.ultimax = it.exrom & ~it.game;
        if (d.region == bsmd_pkg::RG_VIDEO)
            d.local_addr = it.addr & 16'h003F;
        else if (d.region == bsmd_pkg::RG_CIA1 || d.region == bsmd_pkg::RG_CIA2)
            d.local_addr = it.addr & 16'h000F;
        if (it.op == OP_WRITE)
        begin
            case (d.region)
                bsmd_pkg::RG_PORT:
                begin
                    if (it.addr == 16'h0000)
                        port_dir_copy = it.wdata;
                    else
                        port_val_copy = it.wdata;
                end
                bsmd_pkg::RG_RAM, bsmd_pkg::RG_BASIC, bsmd_pkg::RG_CHAR,
                bsmd_pkg::RG_KERNAL:
                begin
                    ram_copy[it.addr] = it.wdata;
                    d.region = bsmd_pkg::RG_RAM;
                end
                bsmd_pkg::RG_COLOR: color_copy[cidx] = it.wdata[3:0];
                default: ;
            endcase
        end
        else
        begin
            case (d.region)
                bsmd_pkg::RG_PORT:
                begin
                    d.rdata = (it.addr == 16'h0000) ? port_dir_copy : port_val_copy;
                    d.dvalid = 1'b1;
                end
                bsmd_pkg::RG_RAM:
                begin
                    d.rdata = ram_copy[it.addr];
                    d.dvalid = 1'b1;
                end
                bsmd_pkg::RG_COLOR:
                begin
                    d.rdata = {it.obus[7:4], color_copy[cidx]};
                    d.dvalid = 1'b1;
                end
                bsmd_pkg::RG_NONE:
                begin
                    d.rdata = it.obus;
                    d.dvalid = 1'b1;
                end
                default: ;
            endcase
        end
        return d;
    endfunction

    task automatic queue_access(input logic wr, input logic [15:0] a, input logic [7:0] wd,
                                input logic g, input logic x, input logic [7:0] ob,
                                input bit drain);
        access_t           it;
        bsmd_pkg::region_t r;
        logic [15:0]       off;
        logic [9:0]        cidx;
        r = lookup_region(gen_port, g, x, a);
        off = a - 16'hD800;
        cidx = off[9:0];
        // Never read a cell that holds nothing yet; store into it instead.
        if (wr == OP_READ && ((r == bsmd_pkg::RG_RAM && !ram_written[a]) ||
                              (r == bsmd_pkg::RG_COLOR && !color_written[cidx])))
            wr = OP_WRITE;
        if (wr == OP_WRITE)
        begin
            if (r == bsmd_pkg::RG_PORT)
            begin
                if (a == 16'h0001)
                    gen_port = wd[2:0];
            end
            else if (r == bsmd_pkg::RG_RAM || r == bsmd_pkg::RG_BASIC ||
                     r == bsmd_pkg::RG_CHAR || r == bsmd_pkg::RG_KERNAL)
            begin
                ram_written[a] = 1'b1;
                written_addrs.push_back(a);
            end
            else if (r == bsmd_pkg::RG_COLOR)
            begin
                color_written[cidx] = 1'b1;
                written_addrs.push_back(a);
            end
        end
        it.op = wr;
        it.addr = a;
        it.wdata = wd;
        it.game = g;
        it.exrom = x;
        it.obus = ob;
        it.drain_first = drain;
        access_queue.push_back(it);
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Driver: present the next item once the previous one was taken.
    always @(negedge clk)
    begin
        access_t it;
        if (rst_n && !(in_valid && driven_count != accepted_count))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (access_queue.size() != 0 &&
                     !(access_queue[0].drain_first && pending_decodes.size() != 0))
            begin
                it = access_queue.pop_front();
                op <= it.op;
                addr <= it.addr;
                write_data <= it.wdata;
                game_line <= it.game;
                exrom_line <= it.exrom;
                open_bus <= it.obus;
                in_valid <= 1'b1;
                driven_count++;
                if (driven_count >= BUSY_FROM && driven_count < BUSY_TO)
                    gap_left = 0;
                else
                    gap_left = pick_idle();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off to fill the pipeline.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ((results_seen >= BUSY_FROM && results_seen < BUSY_TO) ||
                 $urandom_range(0, 3) != 0)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left = pick_idle();
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        access_t it;
        if (rst_n && in_valid && !in_stall)
        begin
            it.op = op;
            it.addr = addr;
            it.wdata = write_data;
            it.game = game_line;
            it.exrom = exrom_line;
            it.obus = open_bus;
            it.drain_first = 1'b0;
            pending_decodes.push_back(decode_access(it));
            accepted_count++;
        end
    end

    always @(posedge clk)
    begin
        decode_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result %0d: region %0d local %h data %h dv %b um %b",
                             results_seen, region, local_addr, read_data, data_valid, ultimax);
                mismatches++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (region !== want.region || local_addr !== want.local_addr ||
                    read_data !== want.rdata || data_valid !== want.dvalid ||
                    ultimax !== want.ultimax)
                begin
                    if (mismatches < 10)
                    begin
                        $display("result %0d: expected region %0d local %h data %h dv %b um %b",
                                 results_seen, want.region, want.local_addr, want.rdata,
                                 want.dvalid, want.ultimax);
                        $display("result %0d: got region %0d local %h data %h dv %b um %b",
                                 results_seen, region, local_addr, read_data,
                                 data_valid, ultimax);
                    end
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int          pick;
        logic        g;
        logic        x;
        logic        wr;
        logic [15:0] a;
        // Port registers after reset, then the direction register at both extremes.
        queue_access(OP_READ,  16'h0000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'h0001, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0);
        queue_access(OP_WRITE, 16'h0000, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'h0000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_WRITE, 16'h0000, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0);
        // Plain RAM in page zero, and a write that lands under the kernal.
        queue_access(OP_WRITE, 16'h0002, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'h0002, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0);
        queue_access(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hFFFF, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        // Color RAM keeps a nibble and reads back under open-bus high bits.
        queue_access(OP_WRITE, 16'hD800, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hD800, 8'h00, 1'b1, 1'b1, 8'hA5, 1'b0);
        // I/O chips (video and CIAs with their masked local address) and the BASIC ROM.
        queue_access(OP_READ,  16'hD07F, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hD41F, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_WRITE, 16'hDC1F, 8'h5A, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hDDFF, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hDE00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hDFFF, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hA000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        // Ultimax: unmapped reads give open bus, unmapped writes vanish.
        queue_access(OP_READ,  16'h1000, 8'h00, 1'b0, 1'b1, 8'h5A, 1'b0);
        queue_access(OP_WRITE, 16'h1000, 8'hC3, 1'b0, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hF000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'h8000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
        // All-RAM bank exposes the byte stored under the kernal; port direction is ignored.
        queue_access(OP_WRITE, 16'h0001, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_READ,  16'hFFFF, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        queue_access(OP_WRITE, 16'h0001, 8'hF7, 1'b1, 1'b1, 8'h00, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) != 0)
            begin
                g = 1'b1;
                x = 1'b1;
            end
            else
            begin
                g = 1'($urandom_range(0, 1));
                x = 1'($urandom_range(0, 1));
            end
            wr = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
            if (pick < 6)
            begin
                wr = OP_WRITE;
                a = 16'h0001;
            end
            else if (pick < 9)
            begin
                a = 16'($urandom_range(0, 1));
            end
            else if (pick < 45 && written_addrs.size() != 0)
            begin
                wr = OP_READ;
                a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            end
            else if (pick < 70)
            begin
                a = {4'hD, 12'($urandom_range(0, 4095))};
            end
            else
            begin
                a = 16'($urandom_range(0, 65535));
            end
            queue_access(wr, a, 8'($urandom_range(0, 255)), g, x, 8'($urandom_range(0, 255)),
                         i == 0 || i == DRAIN_AT);
        end
        total_items = access_queue.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (accepted_count != total_items || pending_decodes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: bank_switched_memory_decoder.f
rtl/bsmd_pkg.sv
rtl/bsmd_decode.sv
rtl/bsmd_mem.sv
rtl/bank_switched_memory_decoder.sv
rtl/bsmd_checker.sv
bench/bank_switched_memory_decoder_tb.sv
